### sv/bciu_pkg.sv
`default_nettype none
package bciu_pkg;
  localparam int unsigned RowsDef = 24;
  localparam int unsigned ColsDef = 8;
  localparam int unsigned ScaleDef = 8;
  localparam int unsigned SampleWidthDef = 16;

  typedef enum logic {
    KindLoad = 1'b0,
    KindReq  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [4:0]         src_row;
    logic [2:0]         src_col;
    logic signed [15:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         out_row;
    logic [5:0]         out_col;
    logic signed [15:0] pixel;
    logic               last;
  } out_word_t;
endpackage
`default_nettype wire

### sv/bicubic_image_upsampler_top.sv
// Load word: written to the image memory when in range, no result.
// Request word in range: SCALE*SCALE pixels, each computed anew (four tap rows read
//   through the single read port, four column cubics and one row cubic of four steps each,
//   then an output step). Output stalls hold the block; once the last pixel is issued,
//   the next word is accepted.
// Reset clears control only; image memory contents are undefined until loaded.
`default_nettype none
module bicubic_image_upsampler_top
  import bciu_pkg::*;
#(
  parameter int unsigned ROWS = RowsDef,
  parameter int unsigned COLS = ColsDef,
  parameter int unsigned SCALE = ScaleDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire in_word_t in_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output out_word_t  out_data_o,
  output logic       out_valid_o,
  input  wire        out_ready_i
);
  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned KW = $clog2(SCALE);
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned Lg = KW;
  // column cubic: 2*S^3*q scale, growth ~ 3*Lg+1 + 4 bits
  localparam int unsigned CB = SW + 3 * Lg + 6;
  localparam int unsigned VB = CB + 3 * Lg + 6;
  localparam int unsigned DSh = 6 * Lg + 2;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StCol   = 5'b00100,
    StRow   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic signed [SW-1:0] mem_q [Depth];
  logic signed [SW-1:0] rd_q;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [KW-1:0] jk_q, ik_q;
  logic [3:0]    tap_q;      // read index: t1*4+t2
  logic          rd_pend_q;  // rd_q holds valid read data
  logic [1:0]    wr_idx_q;
  logic signed [SW-1:0] p_q [4];
  logic signed [CB-1:0] arr_q [4];
  logic [1:0]    step_q;
  logic signed [VB-1:0] acc_q;
  out_word_t     out_q;
  logic          out_v_q;

  wire in_hs = in_valid_i && in_ready_o;
  wire in_rng = (32'(in_data_i.src_row) < ROWS) && (32'(in_data_i.src_col) < COLS);

  // clamped neighbor address
  function automatic logic [AW-1:0] nb_addr(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                            input logic [1:0] dr, input logic [1:0] dc);
    int rr, cc;
    rr = int'(r) + int'(dr) - 1;
    cc = int'(c) + int'(dc) - 1;
    if (rr < 0) rr = 0;
    if (rr > int'(ROWS) - 1) rr = int'(ROWS) - 1;
    if (cc < 0) cc = 0;
    if (cc > int'(COLS) - 1) cc = int'(COLS) - 1;
    return AW'(rr * int'(COLS) + cc);
  endfunction

  assign rd_en = (state_q == StRead);
  assign rd_addr = nb_addr(row_q, col_q, tap_q[3:2], tap_q[1:0]);

  always_ff @(posedge clk_i) begin
    if (in_hs && in_data_i.kind == KindLoad && in_rng) begin
      mem_q[AW'(32'(in_data_i.src_row) * COLS + 32'(in_data_i.src_col))] <=
        SW'(in_data_i.sample);
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // cubic terms, one Horner step per cycle
  logic signed [VB-1:0] q0, q1, q2, q3, cc, aa, bb, hor;
  logic signed [KW:0]   kk;
  always_comb begin
    if (state_q == StCol) begin
      q0 = VB'(p_q[0]); q1 = VB'(p_q[1]); q2 = VB'(p_q[2]); q3 = VB'(p_q[3]);
      kk = {1'b0, jk_q};
    end else begin
      q0 = VB'(arr_q[0]); q1 = VB'(arr_q[1]); q2 = VB'(arr_q[2]); q3 = VB'(arr_q[3]);
      kk = {1'b0, ik_q};
    end
    cc = q2 - q0;
    aa = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    bb = (q1 - q2) * 3 + q3 - q0;
    case (step_q)
      2'd0:    hor = bb;
      2'd1:    hor = (aa <<< Lg) + kk * acc_q;
      2'd2:    hor = (cc <<< (2 * Lg)) + kk * acc_q;
      default: hor = (q1 <<< (3 * Lg + 1)) + kk * acc_q;
    endcase
  end

  logic signed [VB-1:0] mag, rq, rs;
  always_comb begin
    mag = acc_q[VB-1] ? -acc_q : acc_q;
    rq = (mag + (VB'(1) <<< (DSh - 1))) >>> DSh;
    rs = acc_q[VB-1] ? -rq : rq;
  end

  logic [15:0] pix_sat;
  always_comb begin
    if (rs > 32767) pix_sat = 16'h7fff;
    else if (rs < -32768) pix_sat = 16'h8000;
    else pix_sat = rs[15:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_hs && in_data_i.kind == KindReq && in_rng) state_d = StRead;
      StRead: if (rd_pend_q && wr_idx_q == 2'd3) state_d = StCol;
      StCol:  if (step_q == 2'd3) state_d = (tap_q == 4'd0) ? StRow : StRead;
      StRow:  if (step_q == 2'd3) state_d = StOut;
      StOut:  if (!out_v_q || out_ready_i) begin
        state_d = (jk_q == KW'(SCALE - 1) && ik_q == KW'(SCALE - 1)) ? StIdle : StRead;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);
  assign out_data_o = out_q;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      rd_pend_q <= 1'b0;
      tap_q <= '0;
      step_q <= '0;
      wr_idx_q <= '0;
      jk_q <= '0;
      ik_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_ready_i && state_q != StOut) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          row_q <= RW'(in_data_i.src_row);
          col_q <= CW'(in_data_i.src_col);
          jk_q <= '0;
          ik_q <= '0;
          tap_q <= '0;
          rd_pend_q <= 1'b0;
          wr_idx_q <= '0;
        end
        StRead: begin
          if (rd_pend_q) begin
            p_q[wr_idx_q] <= rd_q;
            wr_idx_q <= wr_idx_q + 2'd1;
          end
          if (rd_pend_q && wr_idx_q == 2'd3) begin
            rd_pend_q <= 1'b0;
            step_q <= '0;
          end else begin
            rd_pend_q <= 1'b1;
            tap_q <= tap_q + 4'd1;
          end
        end
        StCol: begin
          acc_q <= hor;
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            arr_q[tap_q[3:2] - 2'd1] <= CB'(hor);
            wr_idx_q <= '0;
          end
        end
        StRow: begin
          acc_q <= hor;
          step_q <= step_q + 2'd1;
        end
        StOut: if (!out_v_q || out_ready_i) begin
          out_v_q <= 1'b1;
          out_q.out_row <= 8'(32'(row_q) * SCALE + 32'(ik_q));
          out_q.out_col <= 6'(32'(col_q) * SCALE + 32'(jk_q));
          out_q.pixel <= pix_sat;
          out_q.last <= (jk_q == KW'(SCALE - 1) && ik_q == KW'(SCALE - 1));
          ik_q <= ik_q + KW'(1);
          if (ik_q == KW'(SCALE - 1)) jk_q <= jk_q + KW'(1);
          tap_q <= '0;
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o)
    else $error("ready while busy");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut && state_d == StIdle |=> out_valid_o && out_data_o.last)
    else $error("last missing");
endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import bciu_pkg::*;

  localparam int Rows = RowsDef;
  localparam int Cols = ColsDef;
  localparam int Scale = ScaleDef;
  localparam longint Denom = 4 * longint'(Scale) ** 6;
  localparam int StallLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  in_word_t  in_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  out_word_t out_data_o;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;

  bicubic_image_upsampler_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  in_word_t  words_to_send[$];
  out_word_t pixels_due[$];
  longint    image_copy[Rows * Cols];
  int        err_cnt = 0;
  logic      in_fire = 1'b0;
  logic      calm = 1'b0;
  int        idle_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint catmull_rom(longint q0, longint q1, longint q2, longint q3,
                                         longint k);
    longint s, c, a, b;
    s = Scale;
    c = q2 - q0;
    a = 2 * q0 - 5 * q1 + 4 * q2 - q3;
    b = 3 * (q1 - q2) + q3 - q0;
    return 2 * s * s * s * q1 + k * (s * s * c + k * (s * a + k * b));
  endfunction

  function automatic int clamp_idx(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_block(int row, int col);
    longint col_pass[4];
    longint p[4];
    longint v, mag, q;
    out_word_t w;
    for (int jk = 0; jk < Scale; jk++) begin
      for (int ik = 0; ik < Scale; ik++) begin
        for (int t1 = 0; t1 < 4; t1++) begin
          for (int t2 = 0; t2 < 4; t2++) begin
            p[t2] = image_copy[clamp_idx(row + t1 - 1, Rows - 1) * Cols
                               + clamp_idx(col + t2 - 1, Cols - 1)];
          end
          col_pass[t1] = catmull_rom(p[0], p[1], p[2], p[3], jk);
        end
        v = catmull_rom(col_pass[0], col_pass[1], col_pass[2], col_pass[3], ik);
        mag = (v < 0) ? -v : v;
        q = (mag + Denom / 2) / Denom;
        if (v < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        w.out_row = 8'(row * Scale + ik);
        w.out_col = 6'(col * Scale + jk);
        w.pixel = 16'(q);
        w.last = (jk == Scale - 1 && ik == Scale - 1);
        pixels_due.push_back(w);
      end
    end
  endfunction

  function automatic void add_word(logic kind, int row, int col, logic [15:0] smp);
    in_word_t w;
    w.kind = kind;
    w.src_row = 5'(row);
    w.src_col = 3'(col);
    w.sample = smp;
    words_to_send.push_back(w);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // scoreboard input: mirror accepted loads, predict pixels for accepted requests
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o && in_data_i.src_row < Rows
        && in_data_i.src_col < Cols) begin
      if (in_data_i.kind == KindLoad)
        image_copy[in_data_i.src_row * Cols + in_data_i.src_col] = in_data_i.sample;
      else
        predict_block(in_data_i.src_row, in_data_i.src_col);
    end
  end

  int in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_fire) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        in_data_i <= words_to_send.pop_front();
        in_valid_i <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  out_word_t due;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected word: row %0d col %0d pixel %0d", out_data_o.out_row,
               out_data_o.out_col, out_data_o.pixel);
        err_cnt++;
      end else begin
        due = pixels_due.pop_front();
        if (out_data_o.out_row !== due.out_row) begin
          $error("out_row: expected %0d, got %0d", due.out_row, out_data_o.out_row);
          err_cnt++;
        end
        if (out_data_o.out_col !== due.out_col) begin
          $error("out_col: expected %0d, got %0d", due.out_col, out_data_o.out_col);
          err_cnt++;
        end
        if (out_data_o.pixel !== due.pixel) begin
          $error("pixel: expected %0d, got %0d", due.pixel, out_data_o.pixel);
          err_cnt++;
        end
        if (out_data_o.last !== due.last) begin
          $error("last: expected %0d, got %0d", due.last, out_data_o.last);
          err_cnt++;
        end
      end
    end
  end

  int out_stall = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 15) out_stall = pick_gap();
      end
    end
  end

  // watchdog; also flips quiet stretches on and off
  always @(posedge clk_i) begin
    if ($urandom_range(0, 1499) == 0) calm <= ~calm;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int r;
    // corner cell with alternating extremes, so pixels saturate
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        add_word(KindLoad, i, j, ((i + j) % 2) ? 16'h8000 : 16'h7fff);
    add_word(KindReq, 0, 0, 16'h0);
    add_word(KindReq, 24, 3, 16'h0);
    add_word(KindReq, 31, 7, 16'hffff);
    add_word(KindLoad, 31, 7, 16'h1234);
    for (int i = 22; i < 24; i++)
      for (int j = 6; j < 8; j++)
        add_word(KindLoad, i, j, (i == j + 16) ? 16'h8000 : 16'h0001);
    add_word(KindReq, 23, 7, 16'h0);
    add_word(KindReq, 0, 0, 16'h0);

    for (int i = 0; i < Rows; i++)
      for (int j = 0; j < Cols; j++)
        if (!((i < 3 && j < 3) || (i >= 22 && j >= 6)))
          add_word(KindLoad, i, j, rand_sample());
    add_word(KindReq, 23, 0, 16'h0);
    add_word(KindReq, 0, 7, 16'h0);

    for (int n = 0; n < 20; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        add_word(KindReq, $urandom_range(0, Rows - 1), $urandom_range(0, Cols - 1),
                 16'($urandom));
      else if (r < 90)
        add_word(KindLoad, $urandom_range(0, Rows - 1), $urandom_range(0, Cols - 1),
                 rand_sample());
      else
        add_word(1'($urandom), $urandom_range(Rows, 31), $urandom_range(0, Cols - 1),
                 rand_sample());
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (words_to_send.size() > 0 || in_valid_i || pixels_due.size() > 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && pixels_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
